FILE: sv/sha1vb_pkg.sv
// Shared types and constants for the mixed-endian SHA-1 byte hash.
// Depends on nothing; the top level, datapath and controller refer to it by scoped names.
`timescale 1ns / 1ps

package sha1vb_pkg;

  // Initial chaining words.
  parameter logic [31:0] H_INIT [0:4] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  // Round constants, one per group of twenty rounds.
  parameter logic [31:0] K_R0 = 32'h5A827999;
  parameter logic [31:0] K_R1 = 32'h6ED9EBA1;
  parameter logic [31:0] K_R2 = 32'h8F1BBCDC;
  parameter logic [31:0] K_R3 = 32'hCA62C1D6;

  parameter logic [7:0] PAD_MARKER  = 8'h80;
  parameter logic [6:0] LAST_ROUND  = 7'd79;
  parameter logic [5:0] LAST_SLOT   = 6'd63;
  parameter logic [5:0] LENGTH_SLOT = 6'd56;
  parameter logic [2:0] LAST_INDEX  = 3'd4;

  // Source of the byte shifted into the block buffer.
  typedef enum logic [1:0] {
    BYTE_INPUT  = 2'd0,
    BYTE_MARKER = 2'd1,
    BYTE_ZERO   = 2'd2,
    BYTE_LENGTH = 2'd3
  } byte_sel_t;

  // Controller states.
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_PAD   = 6'b000010,
    S_LOAD  = 6'b000100,
    S_ROUND = 6'b001000,
    S_ADD   = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       shift;
    byte_sel_t  sel;
    logic       load;
    logic       load_le;
    logic       round;
    logic [6:0] round_num;
    logic       add;
    logic       restart;
    logic [2:0] word_idx;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [5:0] fill;
  } dp_stat_t;

endpackage

FILE: sv/sha1vb_if.sv
// Valid/ready channel interfaces for the input bytes and the digest words.
// Depends on nothing.
`timescale 1ns / 1ps

interface sha1vb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       last;

  modport source (output valid, data_byte, byte_valid, last, input ready);
  modport sink (input valid, data_byte, byte_valid, last, output ready);
endinterface

interface sha1vb_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

FILE: sv/sha1_variant_byte_hash.sv
// A byte that does not complete a block leaves intake open; one that completes a block
// holds intake while the block is loaded, run through 80 rounds at one per cycle and
// added into the chaining words.
// A last item adds one padding byte per cycle up to the block end, one or two more
// compressions, then five digest words, one per cycle while the sink is ready.
// Reset (synchronous, active high) loads the initial chaining words and clears all counters.
`timescale 1ns / 1ps

module sha1_variant_byte_hash (
  input  logic          clk,
  input  logic          rst,
  sha1vb_in_if.sink     in_ch,
  sha1vb_out_if.source  out_ch
);

  sha1vb_pkg::dp_cmd_t  cmd;
  sha1vb_pkg::dp_stat_t stat;

  // Sequencer.
  sha1vb_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_ch.valid),
    .in_byte_valid (in_ch.byte_valid),
    .in_last       (in_ch.last),
    .in_ready      (in_ch.ready),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .word_index    (out_ch.word_index),
    .last_word     (out_ch.last_word),
    .stat          (stat),
    .cmd           (cmd)
  );

  // Buffer, schedule and compression datapath.
  sha1vb_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .data_byte   (in_ch.data_byte),
    .cmd         (cmd),
    .stat        (stat),
    .digest_word (out_ch.digest_word)
  );

endmodule

FILE: sv/sha1vb_datapath.sv
// Datapath: 64-byte block shift buffer, message schedule, working words,
// chaining words and length counter. Depends on sha1vb_pkg.
`timescale 1ns / 1ps

module sha1vb_datapath (
  input  logic                clk,
  input  logic                rst,
  input  logic [7:0]          data_byte,
  input  sha1vb_pkg::dp_cmd_t cmd,
  output sha1vb_pkg::dp_stat_t stat,
  output logic [31:0]         digest_word
);

  logic [7:0]  blk [0:63];
  logic [31:0] sched [0:15];
  logic [31:0] chain [0:4];
  logic [31:0] wa, wb, wc, wd, we;
  logic [5:0]  fill;
  logic [60:0] msg_len;

  logic [63:0] bit_len;
  logic [2:0]  len_idx;
  logic [7:0]  len_byte;
  logic [7:0]  byte_in;
  logic [31:0] w_cur;
  logic [31:0] w_mix;
  logic [31:0] f_val;
  logic [31:0] k_val;
  logic [31:0] t_val;

  // Round function and constant by round group.
  function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] res;
    if (r < 7'd20) begin
      res = (b & c) | (~b & d);
    end else if (r < 7'd40) begin
      res = b ^ c ^ d;
    end else if (r < 7'd60) begin
      res = (b & c) | (b & d) | (c & d);
    end else begin
      res = b ^ c ^ d;
    end
    return res;
  endfunction

  function automatic logic [31:0] round_k(input logic [6:0] r);
    logic [31:0] res;
    if (r < 7'd20) begin
      res = sha1vb_pkg::K_R0;
    end else if (r < 7'd40) begin
      res = sha1vb_pkg::K_R1;
    end else if (r < 7'd60) begin
      res = sha1vb_pkg::K_R2;
    end else begin
      res = sha1vb_pkg::K_R3;
    end
    return res;
  endfunction

  // Length bytes: high half first, each half little-endian.
  assign bit_len  = {msg_len, 3'b000};
  assign len_idx  = {~fill[2], fill[1:0]};
  assign len_byte = bit_len[{len_idx, 3'b000} +: 8];

  // Byte that enters the buffer.
  always_comb begin
    case (cmd.sel)
      sha1vb_pkg::BYTE_INPUT:  byte_in = data_byte;
      sha1vb_pkg::BYTE_MARKER: byte_in = sha1vb_pkg::PAD_MARKER;
      sha1vb_pkg::BYTE_ZERO:   byte_in = 8'h00;
      sha1vb_pkg::BYTE_LENGTH: byte_in = len_byte;
      default:                 byte_in = 8'h00;
    endcase
  end

  // Block buffer: bytes enter at the top, so a full block has byte 0 at the bottom.
  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      for (int i = 0; i < 63; i++) begin
        blk[i] <= blk[i + 1];
      end
      blk[63] <= byte_in;
    end
  end

  // Fill count and message length in bytes.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill    <= '0;
      msg_len <= '0;
    end else begin
      if (cmd.shift) begin
        fill <= fill + 6'd1;
      end
      if (cmd.restart) begin
        msg_len <= '0;
      end else if (cmd.shift && cmd.sel == sha1vb_pkg::BYTE_INPUT) begin
        msg_len <= msg_len + 61'd1;
      end
    end
  end

  assign stat.fill = fill;

  // Schedule word for this round; from round sixteen on, sched[0] holds the word sixteen rounds back.
  assign w_mix = sched[13] ^ sched[8] ^ sched[2] ^ sched[0];
  assign w_cur = (cmd.round_num < 7'd16) ? sched[0] : {w_mix[30:0], w_mix[31]};
  assign f_val = round_f(cmd.round_num, wb, wc, wd);
  assign k_val = round_k(cmd.round_num);
  assign t_val = {wa[26:0], wa[31:27]} + f_val + we + k_val + w_cur;

  // Schedule ring: loaded from the buffer, then shifted once a round.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < 16; i++) begin
        if (cmd.load_le) begin
          sched[i] <= {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
        end else begin
          sched[i] <= {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
        end
      end
    end else if (cmd.round) begin
      for (int i = 0; i < 15; i++) begin
        sched[i] <= sched[i + 1];
      end
      sched[15] <= w_cur;
    end
  end

  // Working words a to e.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      wa <= chain[0];
      wb <= chain[1];
      wc <= chain[2];
      wd <= chain[3];
      we <= chain[4];
    end else if (cmd.round) begin
      wa <= t_val;
      wb <= wa;
      wc <= {wb[1:0], wb[31:2]};
      wd <= wc;
      we <= wd;
    end
  end

  // Chaining words: accumulate after each block, back to the initial value after output.
  always_ff @(posedge clk) begin
    if (rst || cmd.restart) begin
      for (int i = 0; i < 5; i++) begin
        chain[i] <= sha1vb_pkg::H_INIT[i];
      end
    end else if (cmd.add) begin
      chain[0] <= chain[0] + wa;
      chain[1] <= chain[1] + wb;
      chain[2] <= chain[2] + wc;
      chain[3] <= chain[3] + wd;
      chain[4] <= chain[4] + we;
    end
  end

  assign digest_word = chain[cmd.word_idx];

endmodule

FILE: sv/sha1vb_ctrl.sv
// Controller: sequences byte intake, padding, the 80 rounds and digest output.
// Depends on sha1vb_pkg; drives the datapath through sha1vb_pkg::dp_cmd_t.
`timescale 1ns / 1ps

module sha1vb_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_byte_valid,
  input  logic                 in_last,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           word_index,
  output logic                 last_word,
  input  sha1vb_pkg::dp_stat_t stat,
  output sha1vb_pkg::dp_cmd_t  cmd
);

  sha1vb_pkg::state_t state, state_next;
  logic [6:0] rnd, rnd_next;
  logic [2:0] word_idx, word_idx_next;
  logic       le_mode, le_mode_next;
  logic       pend_last, pend_last_next;
  logic       marker_done, marker_done_next;
  logic       two_blocks, two_blocks_next;
  logic       in_fire;
  logic       out_fire;

  assign in_ready   = (state == sha1vb_pkg::S_IDLE);
  assign out_valid  = (state == sha1vb_pkg::S_EMIT);
  assign in_fire    = in_valid && in_ready;
  assign out_fire   = out_valid && out_ready;
  assign word_index = word_idx;
  assign last_word  = (word_idx == sha1vb_pkg::LAST_INDEX);

  // Next state and datapath commands.
  always_comb begin
    state_next       = state;
    rnd_next         = rnd;
    word_idx_next    = word_idx;
    le_mode_next     = le_mode;
    pend_last_next   = pend_last;
    marker_done_next = marker_done;
    two_blocks_next  = two_blocks;
    cmd              = '0;
    cmd.sel          = sha1vb_pkg::BYTE_INPUT;
    cmd.load_le      = le_mode;
    cmd.round_num    = rnd;
    cmd.word_idx     = word_idx;

    unique case (state)
      sha1vb_pkg::S_IDLE: begin
        if (in_fire) begin
          cmd.shift = in_byte_valid;
          if (in_byte_valid && stat.fill == sha1vb_pkg::LAST_SLOT) begin
            state_next     = sha1vb_pkg::S_LOAD;
            le_mode_next   = 1'b1;
            pend_last_next = in_last;
          end else if (in_last) begin
            state_next       = sha1vb_pkg::S_PAD;
            le_mode_next     = 1'b0;
            marker_done_next = 1'b0;
          end
        end
      end
      sha1vb_pkg::S_PAD: begin
        cmd.shift = 1'b1;
        if (!marker_done) begin
          cmd.sel          = sha1vb_pkg::BYTE_MARKER;
          marker_done_next = 1'b1;
          two_blocks_next  = (stat.fill >= sha1vb_pkg::LENGTH_SLOT);
        end else if (stat.fill >= sha1vb_pkg::LENGTH_SLOT && !two_blocks) begin
          cmd.sel = sha1vb_pkg::BYTE_LENGTH;
        end else begin
          cmd.sel = sha1vb_pkg::BYTE_ZERO;
        end
        if (stat.fill == sha1vb_pkg::LAST_SLOT) begin
          state_next   = sha1vb_pkg::S_LOAD;
          le_mode_next = 1'b0;
        end
      end
      sha1vb_pkg::S_LOAD: begin
        cmd.load   = 1'b1;
        rnd_next   = '0;
        state_next = sha1vb_pkg::S_ROUND;
      end
      sha1vb_pkg::S_ROUND: begin
        cmd.round = 1'b1;
        rnd_next  = rnd + 7'd1;
        if (rnd == sha1vb_pkg::LAST_ROUND) begin
          state_next = sha1vb_pkg::S_ADD;
        end
      end
      sha1vb_pkg::S_ADD: begin
        cmd.add  = 1'b1;
        rnd_next = '0;
        if (le_mode) begin
          if (pend_last) begin
            state_next       = sha1vb_pkg::S_PAD;
            le_mode_next     = 1'b0;
            marker_done_next = 1'b0;
            pend_last_next   = 1'b0;
          end else begin
            state_next = sha1vb_pkg::S_IDLE;
          end
        end else if (two_blocks) begin
          two_blocks_next = 1'b0;
          state_next      = sha1vb_pkg::S_PAD;
        end else begin
          word_idx_next = '0;
          state_next    = sha1vb_pkg::S_EMIT;
        end
      end
      sha1vb_pkg::S_EMIT: begin
        if (out_fire) begin
          word_idx_next = word_idx + 3'd1;
          if (word_idx == sha1vb_pkg::LAST_INDEX) begin
            cmd.restart   = 1'b1;
            word_idx_next = '0;
            state_next    = sha1vb_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_next = sha1vb_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= sha1vb_pkg::S_IDLE;
      rnd         <= '0;
      word_idx    <= '0;
      le_mode     <= 1'b0;
      pend_last   <= 1'b0;
      marker_done <= 1'b0;
      two_blocks  <= 1'b0;
    end else begin
      state       <= state_next;
      rnd         <= rnd_next;
      word_idx    <= word_idx_next;
      le_mode     <= le_mode_next;
      pend_last   <= pend_last_next;
      marker_done <= marker_done_next;
      two_blocks  <= two_blocks_next;
    end
  end

  // A block is compressed only once the buffer has wrapped to empty.
  a_load_full: assert property (@(posedge clk) disable iff (rst)
    state == sha1vb_pkg::S_LOAD |-> stat.fill == 6'd0)
    else $error("compression started on a partly filled block");

  // Digest output starts only after padding has completed the final block.
  a_emit_empty: assert property (@(posedge clk) disable iff (rst)
    state == sha1vb_pkg::S_EMIT |-> stat.fill == 6'd0 && !two_blocks)
    else $error("digest output with padding unfinished");

  // The round counter stays within the eighty rounds.
  a_round_range: assert property (@(posedge clk) disable iff (rst)
    state == sha1vb_pkg::S_ROUND |-> rnd <= sha1vb_pkg::LAST_ROUND)
    else $error("round counter ran past the last round");

  // The fifth word taken returns the block to intake.
  a_emit_done: assert property (@(posedge clk) disable iff (rst)
    (out_fire && word_idx == sha1vb_pkg::LAST_INDEX) |=> state == sha1vb_pkg::S_IDLE)
    else $error("block did not return to idle after the last digest word");

  // Intake and output are never offered at once.
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input ready while a digest word is offered");

endmodule

FILE: tb/tb_sha1_variant_byte_hash.sv
// Self-checking testbench for the mixed-endian SHA-1 byte hash.
// Depends on the sha1vb_in_if / sha1vb_out_if channels and sha1_variant_byte_hash.
`timescale 1ns / 1ps

module tb_sha1_variant_byte_hash;

  localparam int SINK_HOLD_CYCLES = 1200;
  localparam int DRAIN_CYCLES     = 400;
  localparam int RANDOM_ITEMS     = 60;

  // Receive-side stall behaviours.
  typedef enum int {
    SINK_FREE    = 0,
    SINK_COIN    = 1,
    SINK_PATTERN = 2,
    SINK_SPARSE  = 3
  } sink_mode_e;

  // One digest word as it leaves the block.
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sha1vb_in_if  in_ch ();
  sha1vb_out_if out_ch ();

  sha1_variant_byte_hash dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // 4 ns clock.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Hash model state.
  logic [31:0] chain_model [5];
  logic [7:0]  block_model [64];
  int unsigned block_fill_model;
  logic [60:0] msg_bytes_model;

  digest_word_t expected_digest_words [$];

  // Sender pacing and run statistics.
  int burst_left    = 0;
  int gap_max       = 0;
  int hold_requests = 0;
  int hold_served   = 0;
  int error_count   = 0;
  int stream_items  = 0;
  int idle_items    = 0;
  int msgs_sent     = 0;
  int bytes_sent    = 0;
  int words_checked = 0;

  function automatic logic [31:0] rotl32(input logic [31:0] v, input int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic void load_initial_chain();
    chain_model[0] = 32'h67452301;
    chain_model[1] = 32'hEFCDAB89;
    chain_model[2] = 32'h98BADCFE;
    chain_model[3] = 32'h10325476;
    chain_model[4] = 32'hC3D2E1F0;
  endfunction

  // Eighty SHA-1 rounds over the buffered block, words read in the given byte order.
  function automatic void compress_model_block(input bit little_end);
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, k, x, t;
    int i;
    int r;
    for (i = 0; i < 16; i++) begin
      if (little_end)
        w[i] = {block_model[4*i+3], block_model[4*i+2], block_model[4*i+1], block_model[4*i]};
      else
        w[i] = {block_model[4*i], block_model[4*i+1], block_model[4*i+2], block_model[4*i+3]};
    end
    a = chain_model[0];
    b = chain_model[1];
    c = chain_model[2];
    d = chain_model[3];
    e = chain_model[4];
    for (r = 0; r < 80; r++) begin
      if (r < 16) begin
        x = w[r];
      end else begin
        x = rotl32(w[(r-3) & 15] ^ w[(r-8) & 15] ^ w[(r-14) & 15] ^ w[r & 15], 1);
        w[r & 15] = x;
      end
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = 32'h5A827999;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = 32'h6ED9EBA1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = 32'h8F1BBCDC;
      end else begin
        f = b ^ c ^ d;
        k = 32'hCA62C1D6;
      end
      t = rotl32(a, 5) + f + e + k + x;
      e = d;
      d = c;
      c = rotl32(b, 30);
      b = a;
      a = t;
    end
    chain_model[0] += a;
    chain_model[1] += b;
    chain_model[2] += c;
    chain_model[3] += d;
    chain_model[4] += e;
  endfunction

  // Advances the model by one accepted item and queues any digest words it causes.
  function automatic void predict_hash_item(input logic [7:0] data, input logic bv,
                                            input logic lst);
    logic [63:0] bit_len;
    digest_word_t want;
    int i;
    if (bv) begin
      block_model[block_fill_model] = data;
      block_fill_model++;
      msg_bytes_model++;
      if (block_fill_model == 64) begin
        compress_model_block(1'b1);
        block_fill_model = 0;
      end
    end
    if (lst) begin
      block_model[block_fill_model] = 8'h80;
      for (i = block_fill_model + 1; i < 64; i++)
        block_model[i] = 8'h00;
      // No room left for the length: an extra block carries only zeros and the length.
      if (block_fill_model >= 56) begin
        compress_model_block(1'b0);
        for (i = 0; i < 64; i++)
          block_model[i] = 8'h00;
      end
      bit_len = {msg_bytes_model, 3'b000};
      for (i = 0; i < 4; i++) begin
        block_model[56+i] = bit_len[32 + 8*i +: 8];
        block_model[60+i] = bit_len[8*i +: 8];
      end
      compress_model_block(1'b0);
      for (i = 0; i < 5; i++) begin
        want.word  = chain_model[i];
        want.index = 3'(i);
        want.last  = (i == 4);
        expected_digest_words.push_back(want);
      end
      load_initial_chain();
      block_fill_model = 0;
      msg_bytes_model  = '0;
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    error_count++;
  endtask

  // Offers one item in bursts with random gaps, waits for acceptance and predicts it.
  task automatic send_item(input logic [7:0] data, input logic bv, input logic lst);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid      <= 1'b1;
    in_ch.data_byte  <= data;
    in_ch.byte_valid <= bv;
    in_ch.last       <= lst;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_hash_item(data, bv, lst);
    if (!bv && !lst)
      idle_items++;
    else
      stream_items++;
    if (bv)
      bytes_sent++;
  endtask

  // Sends one message; fill below zero means random bytes.
  task automatic send_message(input int nbytes, input bit end_on_byte, input int fill,
                              input int idle_pct);
    logic [7:0] b;
    int i;
    for (i = 0; i < nbytes; i++) begin
      if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
        send_item(8'($urandom), 1'b0, 1'b0);
      b = (fill < 0) ? 8'($urandom) : fill[7:0];
      send_item(b, 1'b1, end_on_byte && (i == nbytes - 1));
    end
    if (!end_on_byte || nbytes == 0)
      send_item(8'($urandom), 1'b0, 1'b1);
    msgs_sent++;
  endtask

  // Empty message, single bytes at both extremes, idle items and both ways of ending.
  task automatic test_directed();
    gap_max = 0;
    send_message(0, 1'b0, -1, 0);
    send_item(8'hFF, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    send_message(1, 1'b1, 8'h00, 0);
    send_message(1, 1'b1, 8'hFF, 0);
    send_message(2, 1'b0, 8'hFF, 0);
    send_message(3, 1'b1, -1, 50);
    send_message(0, 1'b0, -1, 0);
  endtask

  // Lengths around the length field and the block end, including a last byte
  // that completes a block.
  task automatic test_block_boundaries();
    int lens [6];
    bit ends [6];
    int i;
    lens = '{55, 56, 63, 64, 64, 65};
    ends = '{1, 0, 1, 1, 0, 1};
    for (i = 0; i < 6; i++) begin
      gap_max = (i % 3 == 0) ? 0 : 6;
      send_message(lens[i], ends[i], -1, (i % 2 == 0) ? 0 : 5);
    end
  endtask

  // The receiver holds off while several messages are offered back to back.
  task automatic test_output_backpressure();
    int i;
    gap_max = 0;
    hold_requests++;
    for (i = 0; i < 4; i++)
      send_message($urandom_range(1, 10), 1'($urandom_range(0, 1)), -1, 0);
    send_message(70, 1'b1, -1, 0);
  endtask

  // Random messages, mostly short, some spanning two or three blocks.
  task automatic test_random_stream();
    int start_count;
    int sel;
    int len;
    start_count = stream_items;
    while (stream_items - start_count < RANDOM_ITEMS) begin
      sel = $urandom_range(0, 99);
      if (sel < 70)
        len = $urandom_range(0, 16);
      else if (sel < 90)
        len = $urandom_range(17, 70);
      else
        len = $urandom_range(100, 140);
      gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      send_message(len, 1'($urandom_range(0, 1)), -1, 10);
    end
  endtask

  // Receiver: changing stall modes, plus a long hold-off on request.
  initial begin : result_sink
    sink_mode_e mode;
    int mode_left;
    logic [7:0] pat;
    mode = SINK_FREE;
    mode_left = 0;
    pat = 8'hFF;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_served != hold_requests) begin
        hold_served++;
        out_ch.ready <= 1'b0;
        repeat (SINK_HOLD_CYCLES) @(posedge clk);
      end else begin
        if (mode_left == 0) begin
          mode = sink_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(16, 160);
          pat = 8'($urandom);
        end
        mode_left--;
        case (mode)
          SINK_FREE: begin
            out_ch.ready <= 1'b1;
          end
          SINK_COIN: begin
            out_ch.ready <= 1'($urandom_range(0, 1));
          end
          SINK_PATTERN: begin
            out_ch.ready <= pat[0];
            pat = {pat[0], pat[7:1]};
          end
          default: begin
            out_ch.ready <= ($urandom_range(0, 3) == 0);
          end
        endcase
      end
    end
  end

  // Each accepted digest word is compared with the oldest expected one.
  always @(posedge clk) begin : digest_checker
    digest_word_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_digest_words.size() == 0) begin
        report_mismatch($sformatf("unexpected digest word %08h index %0d last %b",
                                  out_ch.digest_word, out_ch.word_index, out_ch.last_word));
      end else begin
        want = expected_digest_words.pop_front();
        words_checked++;
        if (out_ch.digest_word !== want.word || out_ch.word_index !== want.index ||
            out_ch.last_word !== want.last)
          report_mismatch($sformatf("digest word: got %08h/%0d/%b, expected %08h/%0d/%b",
                                    out_ch.digest_word, out_ch.word_index, out_ch.last_word,
                                    want.word, want.index, want.last));
      end
    end
  end

  // Main sequence.
  initial begin
    in_ch.valid      <= 1'b0;
    in_ch.data_byte  <= 8'h00;
    in_ch.byte_valid <= 1'b0;
    in_ch.last       <= 1'b0;
    load_initial_chain();
    block_fill_model = 0;
    msg_bytes_model  = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_block_boundaries();
    test_output_backpressure();
    test_random_stream();

    in_ch.valid <= 1'b0;
    while (expected_digest_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Hashed %0d messages: %0d bytes, %0d idle items, %0d digest words checked.",
             msgs_sent, bytes_sent, idle_items, words_checked);
    $display("Included the empty message, block-end lengths and a long receiver hold-off.");
    if (error_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("Timed out with %0d digest words still expected.", expected_digest_words.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule
